@@ rtl/oscillator_divider_search_macros.svh @@
// assertion macros for the oscillator divider search block
// expects signals named clk and rst_n in the scope of each use
`ifndef OSCILLATOR_DIVIDER_SEARCH_MACROS_SVH
`define OSCILLATOR_DIVIDER_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// antecedent in a cycle implies consequent in the same cycle
`define ODS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// antecedent in a cycle implies consequent in the next cycle
`define ODS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ODS_ASSERT_IMPLIES(lbl, ante, cons)
`define ODS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/odsearch_pkg.sv @@
// shared types, constants and divider table of the oscillator divider search
// no dependencies
package odsearch_pkg;

  // field widths
  localparam int TARGET_W = 31;
  localparam int XTAL_W   = 43;
  localparam int DCO_W    = 33;
  localparam int RFREQ_W  = 38;
  localparam int N1_W     = 8;
  localparam int HS_W     = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  // internal widths
  localparam int HF_W    = TARGET_W + HS_W;   // target times high-speed divider
  localparam int FDCO_W  = HF_W + N1_W;       // core frequency while stepping
  localparam int FRAC_W  = 44;                // fixed-point shift of the multiplier
  localparam int DVD_W   = DCO_W + FRAC_W;    // serial dividend
  localparam int DSR_W   = XTAL_W;            // divisor
  localparam int QUO_W   = RFREQ_W;           // quotient register
  localparam int ITER_W  = 7;
  localparam int HS_IDX_W = 3;

  localparam logic [ITER_W-1:0] ITERS_Q = ITER_W'(DCO_W);
  localparam logic [ITER_W-1:0] ITERS_R = ITER_W'(DVD_W);

  localparam logic [N1_W-1:0] N1_LIMIT = 8'd128;
  localparam logic [HS_IDX_W-1:0] HS_LAST = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_FREQ = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PAIR   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_XTAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DCO_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DCO_MAX = 2'd2;

  // register reset values
  localparam logic [XTAL_W-1:0] XTAL_RST    = 43'd7489781760000;
  localparam logic [DCO_W-1:0]  DCO_MIN_RST = 33'd4850000000;
  localparam logic [DCO_W-1:0]  DCO_MAX_RST = 33'd5670000000;

  // divider unit control
  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_rsp_t;

  // high-speed divider order: 11, 9, 7, 6, 5, 4
  function automatic logic [HS_W-1:0] hs_of(input logic [HS_IDX_W-1:0] idx);
    logic [HS_W-1:0] hs;
    case (idx)
      3'd0:    hs = 4'd11;
      3'd1:    hs = 4'd9;
      3'd2:    hs = 4'd7;
      3'd3:    hs = 4'd6;
      3'd4:    hs = 4'd5;
      3'd5:    hs = 4'd4;
      default: hs = 4'd0;
    endcase
    return hs;
  endfunction

endpackage

@@ rtl/odsearch_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// depends on odsearch_pkg
module odsearch_div
  import odsearch_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output div_rsp_t         rsp,
  output logic [QUO_W-1:0] quotient
);

  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DSR_W:0] trial;
  logic [DSR_W:0] diff;
  logic           ge;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = (trial >= {1'b0, dsr_r});
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
      cnt_nxt  = req.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      rem_nxt = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      // a bit leaving the top means the quotient no longer fits
      ovf_nxt = ovf_r | quo_r[QUO_W-1];
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign quotient = quo_r;

endmodule

@@ rtl/oscillator_divider_search.sv @@
// oscillator divider search: one request of a target frequency gives RFREQ,
// N1 and HS dividers and a status. The request is taken when start is high and
// busy is low. Busy stays high from that edge until the cycle that carries the
// result. The result appears for exactly one cycle with out_valid and cannot be
// held off, so the receiver must capture it then. A zero frequency goes from
// idle straight to the output state. Otherwise the search visits each of the
// six high-speed dividers: it forms the target times the divider, finds the
// first N1 with a 33-step serial division and, if that N1 is within the limit,
// forms the core frequency and steps through the N1 candidates, at most 65 of
// them. A closing state then ends the search, and a found pair goes on to RFREQ
// (a 77-step serial division). All divisions share one bit-serial divider unit.
// Configuration registers may only be written while busy is low.
// depends on odsearch_pkg, odsearch_div and oscillator_divider_search_macros.svh
`include "oscillator_divider_search_macros.svh"

module oscillator_divider_search
  import odsearch_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic [TARGET_W-1:0]  in_target_hz,
  // result channel
  output logic                 out_valid,
  output logic [RFREQ_W-1:0]   out_rfreq_word,
  output logic [N1_W-1:0]      out_n1_div,
  output logic [HS_W-1:0]      out_fast_div,
  output logic [STATUS_W-1:0]  out_status,
  // configuration port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [XTAL_W-1:0]    cfg_wdata
);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HF    = 4'd1;
  localparam logic [3:0] S_QDIV  = 4'd2;
  localparam logic [3:0] S_QWAIT = 4'd3;
  localparam logic [3:0] S_N1    = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_RDIV  = 4'd8;
  localparam logic [3:0] S_RWAIT = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // configuration registers
  logic [XTAL_W-1:0] xtal_r;
  logic [DCO_W-1:0]  dco_min_r;
  logic [DCO_W-1:0]  dco_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xtal_r    <= XTAL_RST;
      dco_min_r <= DCO_MIN_RST;
      dco_max_r <= DCO_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_XTAL:    xtal_r    <= cfg_wdata;
        REG_DCO_MIN: dco_min_r <= cfg_wdata[DCO_W-1:0];
        REG_DCO_MAX: dco_max_r <= cfg_wdata[DCO_W-1:0];
        default:     ;
      endcase
    end
  end

  // sequencer and search registers
  logic [3:0]          state_r, state_nxt;
  logic [HS_IDX_W-1:0] k_r, k_nxt;
  logic                found_r, found_nxt;
  logic [TARGET_W-1:0] f_r, f_nxt;
  logic [HF_W-1:0]     hf_r, hf_nxt;
  logic [N1_W-1:0]     n1_r, n1_nxt;
  logic [FDCO_W-1:0]   fdco_r, fdco_nxt;
  logic [DCO_W-1:0]    min_core_r, min_core_nxt;
  logic [N1_W-1:0]     best_n1_r, best_n1_nxt;
  logic [HS_W-1:0]     best_hs_r, best_hs_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [RFREQ_W-1:0]  rfreq_r, rfreq_nxt;

  // result registers
  logic                out_valid_r;
  logic [RFREQ_W-1:0]  out_rfreq_r;
  logic [N1_W-1:0]     out_n1_r;
  logic [HS_W-1:0]     out_hs_r;
  logic [STATUS_W-1:0] out_status_r;

  // shared divider
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [DVD_W-1:0] div_dividend;
  logic [DSR_W-1:0] div_divisor;
  logic [QUO_W-1:0] div_quo;

  odsearch_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp),
    .quotient (div_quo)
  );

  // divider operands: dco_min / (f*hs) for the first N1, fdco * 2^44 / xtal for RFREQ
  always_comb begin
    div_req.start = (state_r == S_QDIV) || (state_r == S_RDIV);
    div_req.iters = (state_r == S_RDIV) ? ITERS_R : ITERS_Q;
    if (state_r == S_RDIV) begin
      div_dividend = {min_core_r, {FRAC_W{1'b0}}};
      div_divisor  = xtal_r;
    end else begin
      div_dividend = {dco_min_r, {FRAC_W{1'b0}}};
      div_divisor  = {{(DSR_W-HF_W){1'b0}}, hf_r};
    end
  end

  logic [FDCO_W-1:0] step;
  logic              over_max;
  logic              in_band;
  logic              better;
  logic              last_hs;

  always_comb begin
    step     = (n1_r == N1_W'(1)) ? {{N1_W{1'b0}}, hf_r}
                                  : {{(N1_W-1){1'b0}}, hf_r, 1'b0};
    over_max = (fdco_r > {{(FDCO_W-DCO_W){1'b0}}, dco_max_r});
    in_band  = (fdco_r >= {{(FDCO_W-DCO_W){1'b0}}, dco_min_r});
    better   = !found_r || (fdco_r[DCO_W-1:0] < min_core_r);
    last_hs  = (k_r == HS_LAST);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    f_nxt         = f_r;
    hf_nxt        = hf_r;
    n1_nxt        = n1_r;
    fdco_nxt      = fdco_r;
    min_core_nxt  = min_core_r;
    best_n1_nxt   = best_n1_r;
    best_hs_nxt   = best_hs_r;
    status_nxt    = status_r;
    rfreq_nxt     = rfreq_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          f_nxt     = in_target_hz;
          k_nxt     = '0;
          found_nxt = 1'b0;
          rfreq_nxt = '0;
          if (in_target_hz == '0) begin
            status_nxt = ST_ZERO_FREQ;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_HF;
          end
        end
      end
      S_HF: begin
        hf_nxt    = {{HS_W{1'b0}}, f_r} * {{TARGET_W{1'b0}}, hs_of(k_r)};
        state_nxt = S_QDIV;
      end
      S_QDIV: state_nxt = S_QWAIT;
      S_QWAIT: begin
        if (div_rsp.done) begin
          state_nxt = S_N1;
        end
      end
      // first N1: zero or odd goes up by one; beyond the limit skips this divider
      S_N1: begin
        if (div_quo > {{(QUO_W-N1_W){1'b0}}, N1_LIMIT}) begin
          state_nxt = last_hs ? S_FIN : S_HF;
          k_nxt     = k_r + 1'b1;
        end else begin
          if ((div_quo == '0) || div_quo[0]) begin
            n1_nxt = div_quo[N1_W-1:0] + 1'b1;
          end else begin
            n1_nxt = div_quo[N1_W-1:0];
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        fdco_nxt  = {{N1_W{1'b0}}, hf_r} * {{HF_W{1'b0}}, n1_r};
        state_nxt = S_CHK;
      end
      // one candidate per cycle
      S_CHK: begin
        if ((n1_r > N1_LIMIT) || over_max) begin
          state_nxt = last_hs ? S_FIN : S_HF;
          k_nxt     = k_r + 1'b1;
        end else begin
          if (in_band && better) begin
            found_nxt     = 1'b1;
            min_core_nxt  = fdco_r[DCO_W-1:0];
            best_n1_nxt   = n1_r;
            best_hs_nxt   = hs_of(k_r);
          end
          n1_nxt   = (n1_r == N1_W'(1)) ? N1_W'(2) : n1_r + N1_W'(2);
          fdco_nxt = fdco_r + step;
        end
      end
      S_FIN: begin
        if (found_r) begin
          state_nxt = S_RDIV;
        end else begin
          status_nxt = ST_NO_PAIR;
          state_nxt  = S_OUT;
        end
      end
      S_RDIV: state_nxt = S_RWAIT;
      S_RWAIT: begin
        if (div_rsp.done) begin
          rfreq_nxt  = div_rsp.ovf ? {RFREQ_W{1'b1}} : div_quo;
          status_nxt = ST_OK;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      found_r     <= found_nxt;
      out_valid_r <= (state_r == S_OUT);
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    f_r         <= f_nxt;
    hf_r        <= hf_nxt;
    n1_r        <= n1_nxt;
    fdco_r      <= fdco_nxt;
    min_core_r  <= min_core_nxt;
    best_n1_r   <= best_n1_nxt;
    best_hs_r   <= best_hs_nxt;
    status_r    <= status_nxt;
    rfreq_r     <= rfreq_nxt;
  end

  // result register, error results carry zero dividers
  always_ff @(posedge clk) begin
    if (state_r == S_OUT) begin
      out_status_r <= status_r;
      out_rfreq_r  <= rfreq_r;
      out_n1_r     <= (status_r == ST_OK) ? best_n1_r : '0;
      out_hs_r     <= (status_r == ST_OK) ? best_hs_r : '0;
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_rfreq_word = out_rfreq_r;
  assign out_n1_div     = out_n1_r;
  assign out_fast_div   = out_hs_r;
  assign out_status     = out_status_r;

  // checks
  `ODS_ASSERT_NEXT(a_out_after_out_state, state_r == S_OUT, out_valid_r)
  `ODS_ASSERT_IMPLIES(a_ok_has_dividers, out_valid_r && (out_status_r == ST_OK), (out_hs_r != '0) && (out_n1_r != '0))
  `ODS_ASSERT_IMPLIES(a_best_n1_form, found_r, (best_n1_r == N1_W'(1)) || !best_n1_r[0])
  `ODS_ASSERT_IMPLIES(a_div_done_only_waiting, div_rsp.done, (state_r == S_QWAIT) || (state_r == S_RWAIT))

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// testbench for oscillator_divider_search: a directed table, then random phases
// over register settings, each result checked against a local search model
// depends on odsearch_pkg and the oscillator_divider_search rtl

module testbench
  import odsearch_pkg::*;
();

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 55;
  localparam int MAX_GAP      = 14;
  localparam int REPORT_MAX   = 10;
  localparam int TAIL_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 2500000;
  localparam int DIR_ROWS     = 29;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [RFREQ_W-1:0]   RFREQ_SAT  = '1;
  localparam logic [63:0]          TARGET_TOP = 64'd2147483647;
  localparam logic [63:0]          DCO_TOP    = 64'h1_FFFF_FFFF;
  localparam logic [XTAL_W-1:0]    XTAL_TOP   = '1;

  // high-speed dividers in search order, first entry in the top nibble
  localparam logic [6*HS_W-1:0] HS_ORDER = {4'd11, 4'd9, 4'd7, 4'd6, 4'd5, 4'd4};

  typedef struct packed {
    logic [RFREQ_W-1:0]  rfreq;
    logic [N1_W-1:0]     n1;
    logic [HS_W-1:0]     hs;
    logic [STATUS_W-1:0] status;
  } divider_choice_t;

  // request with predicted result, request with a typed error, register write
  typedef enum logic [1:0] {ROW_REQ, ROW_REQ_ERR, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [XTAL_W-1:0]    value;
    logic [STATUS_W-1:0]  err;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [TARGET_W-1:0]  in_target_hz = '0;
  logic                 out_valid;
  logic [RFREQ_W-1:0]   out_rfreq_word;
  logic [N1_W-1:0]      out_n1_div;
  logic [HS_W-1:0]      out_fast_div;
  logic [STATUS_W-1:0]  out_status;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [XTAL_W-1:0]    cfg_wdata = '0;

  // local copy of the register file
  logic [XTAL_W-1:0] xtal_q16 = XTAL_RST;
  logic [DCO_W-1:0]  dco_lo = DCO_MIN_RST;
  logic [DCO_W-1:0]  dco_hi = DCO_MAX_RST;

  divider_choice_t     search_q[$];
  bit                  err_row_pending = 1'b0;
  logic [STATUS_W-1:0] err_row_status = ST_OK;
  int                  fault_cnt = 0;

  oscillator_divider_search i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_target_hz   (in_target_hz),
    .out_valid      (out_valid),
    .out_rfreq_word (out_rfreq_word),
    .out_n1_div     (out_n1_div),
    .out_fast_div   (out_fast_div),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // divider search and multiplier for one target under the current registers
  function automatic divider_choice_t choose_dividers(input logic [TARGET_W-1:0] target);
    divider_choice_t choice;
    logic [63:0]     f, hs, n1, fdco, min_core;
    logic [127:0]    scaled, quo;
    bit              found, past_max;
    choice = '0;
    found = 1'b0;
    min_core = '0;
    f = 64'(target);
    if (f == 0) begin
      choice.status = ST_ZERO_FREQ;
      return choice;
    end
    for (int k = 0; k < 6; k++) begin
      hs = 64'(HS_ORDER[HS_W*(5-k) +: HS_W]);
      // first n1 is 1 or even
      n1 = (64'(dco_lo) / hs) / f;
      if (n1 == 0 || n1[0]) n1 = n1 + 64'd1;
      past_max = 1'b0;
      while (n1 <= 64'(N1_LIMIT) && !past_max) begin
        fdco = f * hs * n1;
        if (fdco > 64'(dco_hi)) begin
          past_max = 1'b1;
        end else begin
          // strictly smaller wins, so a tie keeps the earlier pair
          if (fdco >= 64'(dco_lo) && (!found || fdco < min_core)) begin
            found = 1'b1;
            min_core = fdco;
            choice.n1 = n1[N1_W-1:0];
            choice.hs = hs[HS_W-1:0];
          end
          n1 = n1 + ((n1 == 64'd1) ? 64'd1 : 64'd2);
        end
      end
    end
    if (!found) begin
      choice.status = ST_NO_PAIR;
      return choice;
    end
    // rfreq = fdco * 2^44 / xtal, saturated; a zero crystal saturates too
    if (xtal_q16 == '0) begin
      choice.rfreq = RFREQ_SAT;
    end else begin
      scaled = 128'(min_core) << FRAC_W;
      quo = scaled / 128'(xtal_q16);
      choice.rfreq = (quo > 128'(RFREQ_SAT)) ? RFREQ_SAT : quo[RFREQ_W-1:0];
    end
    choice.status = ST_OK;
    return choice;
  endfunction

  // request capture and result checking
  always @(posedge clk) begin
    divider_choice_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (search_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= REPORT_MAX)
            $display("%0t: result with no request outstanding", $realtime);
        end else begin
          want = search_q.pop_front();
          if (out_rfreq_word !== want.rfreq || out_n1_div !== want.n1 ||
              out_fast_div !== want.hs || out_status !== want.status) begin
            fault_cnt++;
            if (fault_cnt <= REPORT_MAX)
              $display("%0t: expected rfreq %h n1 %0d hs %0d status %0d, got rfreq %h n1 %0d hs %0d status %0d",
                       $realtime, want.rfreq, want.n1, want.hs, want.status,
                       out_rfreq_word, out_n1_div, out_fast_div, out_status);
          end
        end
      end
      if (start && !busy) begin
        if (err_row_pending) begin
          want = '0;
          want.status = err_row_status;
          err_row_pending = 1'b0;
        end else begin
          want = choose_dividers(in_target_hz);
        end
        search_q.push_back(want);
      end
    end
  end

  // present one request, hold it until taken, then idle for the given gap; a zero gap leaves start high
  task automatic send_request(input logic [TARGET_W-1:0] target, input int gap);
    start <= 1'b1;
    in_target_hz <= target;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // stop requesting and wait for every outstanding result
  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk);
    while (search_q.size() != 0 || busy) @(negedge clk);
  endtask

  // register write, only called while the block is idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [XTAL_W-1:0] data);
    case (index)
      REG_XTAL:    xtal_q16 = data;
      REG_DCO_MIN: dco_lo = data[DCO_W-1:0];
      REG_DCO_MAX: dco_hi = data[DCO_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    stim_row_t           dir_table [DIR_ROWS];
    logic [63:0]         span, fdco_pick, divisor, pick;
    logic [XTAL_W-1:0]   lo_pick;
    logic [TARGET_W-1:0] target;
    logic [N1_W-1:0]     n1_pick;
    int                  gap_top, roll, hs_k;

    // reset values, extremes of the target, window edges
    dir_table[0]  = '{ROW_REQ_ERR, REG_XTAL, 43'd0, ST_ZERO_FREQ};
    dir_table[1]  = '{ROW_REQ_ERR, REG_XTAL, 43'd2147483647, ST_NO_PAIR};
    dir_table[2]  = '{ROW_REQ_ERR, REG_XTAL, 43'd1, ST_NO_PAIR};
    dir_table[3]  = '{ROW_REQ, REG_XTAL, 43'd100000000, ST_OK};
    dir_table[4]  = '{ROW_REQ, REG_XTAL, 43'd10000000, ST_OK};
    dir_table[5]  = '{ROW_REQ, REG_XTAL, 43'd156250000, ST_OK};
    dir_table[6]  = '{ROW_REQ, REG_XTAL, 43'd3500000, ST_OK};
    dir_table[7]  = '{ROW_REQ, REG_XTAL, 43'd1417500000, ST_OK};
    dir_table[8]  = '{ROW_REQ, REG_XTAL, 43'd1212500000, ST_OK};
    // write to an index with no register behind it
    dir_table[9]  = '{ROW_CFG, REG_UNUSED, 43'h7FF_FFFF_FFFF, ST_OK};
    dir_table[10] = '{ROW_REQ, REG_XTAL, 43'd100000000, ST_OK};
    // zero crystal, tiny crystal, largest crystal
    dir_table[11] = '{ROW_CFG, REG_XTAL, 43'd0, ST_OK};
    dir_table[12] = '{ROW_REQ, REG_XTAL, 43'd100000000, ST_OK};
    dir_table[13] = '{ROW_CFG, REG_XTAL, 43'd1, ST_OK};
    dir_table[14] = '{ROW_REQ, REG_XTAL, 43'd10000000, ST_OK};
    dir_table[15] = '{ROW_CFG, REG_XTAL, 43'h7FF_FFFF_FFFF, ST_OK};
    dir_table[16] = '{ROW_REQ, REG_XTAL, 43'd156250000, ST_OK};
    // minimum above maximum
    dir_table[17] = '{ROW_CFG, REG_DCO_MIN, 43'h1_FFFF_FFFF, ST_OK};
    dir_table[18] = '{ROW_CFG, REG_DCO_MAX, 43'd0, ST_OK};
    dir_table[19] = '{ROW_REQ_ERR, REG_XTAL, 43'd100000000, ST_NO_PAIR};
    dir_table[20] = '{ROW_REQ_ERR, REG_XTAL, 43'd0, ST_ZERO_FREQ};
    // widest window
    dir_table[21] = '{ROW_CFG, REG_DCO_MIN, 43'd0, ST_OK};
    dir_table[22] = '{ROW_CFG, REG_DCO_MAX, 43'h1_FFFF_FFFF, ST_OK};
    dir_table[23] = '{ROW_REQ, REG_XTAL, 43'd1, ST_OK};
    dir_table[24] = '{ROW_REQ, REG_XTAL, 43'd2147483647, ST_OK};
    dir_table[25] = '{ROW_REQ, REG_XTAL, 43'd12345678, ST_OK};
    // back to reset values
    dir_table[26] = '{ROW_CFG, REG_XTAL, XTAL_RST, ST_OK};
    dir_table[27] = '{ROW_CFG, REG_DCO_MIN, 43'(DCO_MIN_RST), ST_OK};
    dir_table[28] = '{ROW_CFG, REG_DCO_MAX, 43'(DCO_MAX_RST), ST_OK};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    for (int r = 0; r < DIR_ROWS; r++) begin
      case (dir_table[r].kind)
        ROW_CFG: begin
          wait_idle();
          write_register(dir_table[r].index, dir_table[r].value);
        end
        ROW_REQ_ERR: begin
          err_row_pending = 1'b1;
          err_row_status = dir_table[r].err;
          send_request(dir_table[r].value[TARGET_W-1:0], $urandom_range(0, MAX_GAP));
        end
        default: begin
          send_request(dir_table[r].value[TARGET_W-1:0], $urandom_range(0, MAX_GAP));
        end
      endcase
    end

    // random phases, each under its own register setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      if (p > 0) begin
        case ($urandom_range(0, 5))
          0: begin
            // realistic part with spread
            write_register(REG_XTAL, XTAL_RST + XTAL_W'($urandom_range(0, 32'h3FFF_FFFF))
                                     - XTAL_W'(32'h2000_0000));
            lo_pick = 43'd4000000000 + XTAL_W'($urandom_range(0, 1000000000));
            write_register(REG_DCO_MIN, lo_pick);
            write_register(REG_DCO_MAX, lo_pick + XTAL_W'($urandom_range(0, 1500000000)));
          end
          1: begin
            // nearly the whole core range
            write_register(REG_DCO_MIN, XTAL_W'($urandom_range(0, 1000)));
            write_register(REG_DCO_MAX, XTAL_W'(DCO_TOP) - XTAL_W'($urandom_range(0, 1000)));
          end
          2: begin
            // crystal at its extremes
            case ($urandom_range(0, 2))
              0:       write_register(REG_XTAL, 43'd1);
              1:       write_register(REG_XTAL, XTAL_TOP);
              default: write_register(REG_XTAL, XTAL_W'($urandom_range(1, 100000)));
            endcase
            write_register(REG_DCO_MIN, 43'(DCO_MIN_RST));
            write_register(REG_DCO_MAX, 43'(DCO_MAX_RST));
          end
          3: begin
            // full random words, upper bits of the core limits dropped
            write_register(REG_XTAL, XTAL_W'({$urandom, $urandom}));
            write_register(REG_DCO_MIN, XTAL_W'({$urandom, $urandom}));
            write_register(REG_DCO_MAX, XTAL_W'({$urandom, $urandom}));
          end
          4: begin
            // narrow window, pairs are rare
            lo_pick = XTAL_W'(64'd100000000 + {$urandom, $urandom} % 64'd6000000000);
            write_register(REG_DCO_MIN, lo_pick);
            write_register(REG_DCO_MAX, lo_pick + XTAL_W'($urandom_range(0, 1000)));
          end
          default: begin
            write_register(REG_XTAL, XTAL_RST);
            write_register(REG_DCO_MIN, 43'(DCO_MIN_RST));
            write_register(REG_DCO_MAX, 43'(DCO_MAX_RST));
          end
        endcase
      end
      if ($urandom_range(0, 3) == 0)
        write_register(REG_UNUSED, XTAL_W'({$urandom, $urandom}));
      gap_top = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        target = TARGET_W'($urandom);
        if (roll < 70) begin
          // target built from a divider pair and a core frequency in the window
          hs_k = $urandom_range(0, 5);
          n1_pick = ($urandom_range(0, 7) == 0) ? 8'd1 : 8'(2 * $urandom_range(1, 64));
          divisor = 64'(HS_ORDER[HS_W*(5-hs_k) +: HS_W]) * 64'(n1_pick);
          if (dco_hi >= dco_lo) begin
            span = 64'(dco_hi) - 64'(dco_lo) + 64'd1;
            fdco_pick = 64'(dco_lo) + ({$urandom, $urandom} % span);
          end else begin
            fdco_pick = {$urandom, $urandom} % DCO_TOP;
          end
          pick = fdco_pick / divisor;
          if (pick != 0 && pick <= TARGET_TOP) target = pick[TARGET_W-1:0];
        end else if (roll < 76) begin
          target = '0;
        end else if (roll < 86) begin
          target = TARGET_W'($urandom_range(1, 2000));
        end else if (roll < 91) begin
          target = TARGET_W'(TARGET_TOP - 64'($urandom_range(0, 100000)));
        end
        // now and then let the block drain completely
        if ($urandom_range(0, 24) == 0) wait_idle();
        send_request(target, $urandom_range(0, gap_top));
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // run limit
  initial begin : watchdog
    for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
